@@ src/cbad_pkg.sv @@
// Shared types, target codes and address map constants for the console bus address decoder.
package cbad_pkg;

   // Target codes carried in the result word.
   localparam logic [4:0] T_LOCAL    = 5'd0;
   localparam logic [4:0] T_BOOT     = 5'd1;
   localparam logic [4:0] T_CART     = 5'd2;
   localparam logic [4:0] T_UNUSABLE = 5'd3;
   localparam logic [4:0] T_AUDIO    = 5'd4;
   localparam logic [4:0] T_JOYPAD   = 5'd5;
   localparam logic [4:0] T_SDATA    = 5'd6;
   localparam logic [4:0] T_SCTL     = 5'd7;
   localparam logic [4:0] T_DIV      = 5'd8;
   localparam logic [4:0] T_COUNTER  = 5'd9;
   localparam logic [4:0] T_MODULO   = 5'd10;
   localparam logic [4:0] T_TCTL     = 5'd11;
   localparam logic [4:0] T_IFLAG    = 5'd12;
   localparam logic [4:0] T_VIDEO    = 5'd13;
   localparam logic [4:0] T_DMA      = 5'd14;
   localparam logic [4:0] T_IENABLE  = 5'd15;
   localparam logic [4:0] T_IGNORED  = 5'd16;
   localparam logic [4:0] T_ERROR    = 5'd17;

   // Access kinds.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Which local memory an access uses.
   localparam logic [1:0] RAM_NONE = 2'd0;
   localparam logic [1:0] RAM_MAIN = 2'd1;
   localparam logic [1:0] RAM_AUX  = 2'd2;

   // Main memory holds video RAM (lower half) and work RAM (upper half).
   localparam int MAIN_DEPTH = 16384;
   localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
   // Aux memory holds sprite attribute RAM (160 bytes) then high RAM (127 bytes).
   localparam int SPRITE_DEPTH = 160;
   localparam int HIGH_DEPTH   = 127;
   localparam int AUX_DEPTH    = SPRITE_DEPTH + HIGH_DEPTH;
   localparam int AUX_AW       = $clog2(AUX_DEPTH);
   localparam logic [AUX_AW-1:0] AUX_HIGH_BASE = AUX_AW'(SPRITE_DEPTH);

   // Address map boundaries.
   localparam logic [15:0] ADDR_BOOT_END   = 16'h00FF;
   localparam logic [15:0] ADDR_CART_END   = 16'h7FFF;
   localparam logic [15:0] ADDR_VRAM_END   = 16'h9FFF;
   localparam logic [15:0] ADDR_XRAM_END   = 16'hBFFF;
   localparam logic [15:0] ADDR_WRAM_END   = 16'hDFFF;
   localparam logic [15:0] ADDR_ECHO_END   = 16'hFDFF;
   localparam logic [15:0] ADDR_OAM_END    = 16'hFE9F;
   localparam logic [15:0] ADDR_UNUSED_END = 16'hFEFF;
   localparam logic [15:0] ADDR_IO_END     = 16'hFF7F;
   localparam logic [15:0] ADDR_HRAM_END   = 16'hFFFE;

   // IO registers with special handling.
   localparam logic [15:0] IO_JOYPAD  = 16'hFF00;
   localparam logic [15:0] IO_SDATA   = 16'hFF01;
   localparam logic [15:0] IO_SCTL    = 16'hFF02;
   localparam logic [15:0] IO_DIV     = 16'hFF04;
   localparam logic [15:0] IO_COUNTER = 16'hFF05;
   localparam logic [15:0] IO_MODULO  = 16'hFF06;
   localparam logic [15:0] IO_TCTL    = 16'hFF07;
   localparam logic [15:0] IO_IFLAG   = 16'hFF0F;
   localparam logic [15:0] IO_AUDIO_LO = 16'hFF10;
   localparam logic [15:0] IO_AUDIO_HI = 16'hFF3F;
   localparam logic [15:0] IO_LCDC    = 16'hFF40;
   localparam logic [15:0] IO_STAT    = 16'hFF41;
   localparam logic [15:0] IO_SCY     = 16'hFF42;
   localparam logic [15:0] IO_SCX     = 16'hFF43;
   localparam logic [15:0] IO_LINE    = 16'hFF44;
   localparam logic [15:0] IO_LYC     = 16'hFF45;
   localparam logic [15:0] IO_DMA     = 16'hFF46;
   localparam logic [15:0] IO_BGP     = 16'hFF47;
   localparam logic [15:0] IO_OBP0    = 16'hFF48;
   localparam logic [15:0] IO_OBP1    = 16'hFF49;
   localparam logic [15:0] IO_WY      = 16'hFF4A;
   localparam logic [15:0] IO_WX      = 16'hFF4B;
   localparam logic [15:0] IO_SPEED   = 16'hFF4D;
   localparam logic [15:0] IO_BOOT_OFF = 16'hFF50;
   localparam logic [15:0] IO_UNUSED  = 16'hFF7F;

   // Boot ROM is hidden once the disable byte holds this value.
   localparam logic [7:0] BOOT_DISABLED = 8'h01;
   localparam logic [7:0] BYTE_ONES     = 8'hFF;

   // Input word.
   typedef struct packed {
      logic        kind;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [4:0]  target;
      logic [15:0] local_address;
      logic [7:0]  forward_data;
      logic [7:0]  read_data;
   } rsp_type;

   // Decoder output: the result word with an immediate read byte, plus memory controls.
   typedef struct packed {
      rsp_type            rsp;
      logic [1:0]         ram_sel;
      logic [MAIN_AW-1:0] main_addr;
      logic [AUX_AW-1:0]  aux_addr;
      logic               boot_wr;
   } dec_type;

endpackage

@@ src/cbad_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module cbad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable with write strobe; otherwise a read updates the output register.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/cbad_decode.sv @@
// Address map decode of one bus access into a target, local address and memory controls.
module cbad_decode
   import cbad_pkg::*;
(
   input  req_type    req,
   input  logic [7:0] boot_byte,
   output dec_type    dec
);

   logic        wr;
   logic [15:0] a;

   assign wr = (req.kind == KIND_WRITE);
   assign a  = req.bus_address;

   always_comb begin
      logic [4:0] tgt;
      logic [7:0] rd;
      logic [7:0] fwd;

      tgt = T_ERROR;
      rd  = 8'h00;
      dec = '0;

      // Region decode.
      if (a <= ADDR_CART_END) begin
         if (!wr && a <= ADDR_BOOT_END && boot_byte != BOOT_DISABLED) begin
            tgt = T_BOOT;
         end else begin
            tgt = T_CART;
         end
      end else if (a <= ADDR_VRAM_END) begin
         tgt = T_LOCAL;
         dec.ram_sel   = RAM_MAIN;
         dec.main_addr = {1'b0, a[12:0]};
      end else if (a <= ADDR_XRAM_END) begin
         tgt = T_CART;
      end else if (a <= ADDR_ECHO_END) begin
         // Work RAM and its echo both land on the low 13 address bits.
         tgt = T_LOCAL;
         dec.ram_sel   = RAM_MAIN;
         dec.main_addr = {1'b1, a[12:0]};
      end else if (a <= ADDR_OAM_END) begin
         tgt = T_LOCAL;
         dec.ram_sel  = RAM_AUX;
         dec.aux_addr = {1'b0, a[7:0]};
      end else if (a <= ADDR_UNUSED_END) begin
         tgt = T_UNUSABLE;
         rd  = BYTE_ONES;
      end else if (a <= ADDR_IO_END) begin
         if (a >= IO_AUDIO_LO && a <= IO_AUDIO_HI) begin
            tgt = T_AUDIO;
         end else begin
            unique case (a) inside
               IO_JOYPAD:  tgt = T_JOYPAD;
               IO_SDATA:   tgt = T_SDATA;
               IO_SCTL: begin
                  tgt = T_SCTL;
                  rd  = BYTE_ONES;
               end
               IO_DIV:     tgt = T_DIV;
               IO_COUNTER: tgt = T_COUNTER;
               IO_MODULO:  tgt = T_MODULO;
               IO_TCTL:    tgt = T_TCTL;
               IO_IFLAG:   tgt = T_IFLAG;
               IO_LCDC, IO_STAT, IO_SCY, IO_SCX, IO_LINE, IO_LYC,
               IO_BGP, IO_OBP0, IO_OBP1, IO_WY, IO_WX:
                  tgt = T_VIDEO;
               IO_DMA:     tgt = wr ? T_DMA : T_ERROR;
               IO_SPEED:   tgt = wr ? T_IGNORED : T_LOCAL;
               IO_BOOT_OFF: begin
                  tgt = T_LOCAL;
                  rd  = boot_byte;
                  dec.boot_wr = wr;
               end
               IO_UNUSED:  tgt = wr ? T_IGNORED : T_ERROR;
               default:    tgt = T_ERROR;
            endcase
         end
      end else if (a <= ADDR_HRAM_END) begin
         tgt = T_LOCAL;
         dec.ram_sel  = RAM_AUX;
         dec.aux_addr = AUX_HIGH_BASE + {2'b00, a[6:0]};
      end else begin
         tgt = T_IENABLE;
      end

      // Forward the write byte to external targets; the line register gets zero.
      fwd = 8'h00;
      if (wr && tgt != T_LOCAL && tgt != T_UNUSABLE && tgt != T_IGNORED &&
          tgt != T_ERROR && a != IO_LINE) begin
         fwd = req.write_data;
      end

      dec.rsp.target        = tgt;
      dec.rsp.local_address = (tgt == T_LOCAL) ? 16'h0000 : a;
      dec.rsp.forward_data  = fwd;
      dec.rsp.read_data     = wr ? 8'h00 : rd;
      // Writes need no memory data on the result side.
      if (wr && dec.ram_sel != RAM_NONE) begin
         dec.rsp.read_data = 8'h00;
      end
   end

endmodule

@@ src/console_bus_address_decoder.sv @@
// Top level of the console bus address decoder: accept stage, local memories, result register.
//
// Usage: each request word on req_data is one bus access (read or write) with its
// 16-bit address and write byte. The block answers with exactly one response word
// on rsp_data naming the target, the local address, the byte forwarded to the target
// and the byte answered locally (memory contents or fixed values).
// Both channels use valid/stall: a word moves at a rising edge with valid high and
// stall low. rsp_valid comes straight from a register.
// Timing: the accepting edge loads the access stage and the registered memory read;
// the response register, which drives rsp_valid, loads from the access stage when it
// advances. Throughput is one word per cycle while the receiver does not stall; an
// access to a local memory uses its single port at the accepting edge only, and a
// read following a write to the same byte sees the new value.
// When the receiver stalls, the response register holds its word, the stage behind
// it fills, and then req_stall rises until the response is taken.
// Reset clears both valid flags and sets the boot-disable byte to zero, so the boot
// ROM overlays the low 256 read addresses. RAM contents are undefined until written
// and take no clearing pass.
module console_bus_address_decoder
   import cbad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dec_type    dec;
   logic [7:0] boot_ff;
   logic [7:0] boot_in;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   rsp_type    s1_rsp_ff;
   logic [1:0] s1_sel_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       accept;
   logic       s1_advance;
   logic       main_en;
   logic       aux_en;
   logic [7:0] main_rdata;
   logic [7:0] aux_rdata;
   logic       is_write;

   // Decode the incoming word.
   cbad_decode u_decode (
      .req       (req_data),
      .boot_byte (boot_ff),
      .dec       (dec)
   );

   // Handshake: the access stage moves on whenever the response register is free.
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !s1_advance;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);
   assign is_write     = (req_data.kind == KIND_WRITE);

   // Memory accesses are issued at the accepting edge.
   assign main_en = accept && (dec.ram_sel == RAM_MAIN);
   assign aux_en  = accept && (dec.ram_sel == RAM_AUX);

   cbad_ram #(
      .WIDTH (8),
      .DEPTH (MAIN_DEPTH)
   ) u_main_ram (
      .clock (clock),
      .en    (main_en),
      .we    (is_write),
      .addr  (dec.main_addr),
      .wdata (req_data.write_data),
      .rdata (main_rdata)
   );

   cbad_ram #(
      .WIDTH (8),
      .DEPTH (AUX_DEPTH)
   ) u_aux_ram (
      .clock (clock),
      .en    (aux_en),
      .we    (is_write),
      .addr  (dec.aux_addr),
      .wdata (req_data.write_data),
      .rdata (aux_rdata)
   );

   // Boot-disable byte is written by an accepted write to its register.
   assign boot_in = (accept && dec.boot_wr) ? req_data.write_data : boot_ff;

   // Response word: memory read data replaces the immediate byte for memory reads.
   always_comb begin
      rsp_in = s1_rsp_ff;
      case (s1_sel_ff)
         RAM_MAIN: rsp_in.read_data = main_rdata;
         RAM_AUX:  rsp_in.read_data = aux_rdata;
         default:  rsp_in.read_data = s1_rsp_ff.read_data;
      endcase
      if (!s1_advance) begin
         rsp_in = rsp_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff      <= 8'h00;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         boot_ff      <= boot_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff <= dec.rsp;
         s1_sel_ff <= is_write ? RAM_NONE : dec.ram_sel;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
